[hw/rtl/stbl_pkg.sv]
// Shared types and constants for the stereo two-stage biquad lowpass.
package stbl_pkg;

  localparam int COEF_W         = 32;
  localparam int HIST_W         = 32;
  localparam int HIST_DEPTH     = 8;
  localparam int HIST_AW        = 3;
  localparam int COEF_FRAC_BITS = 30;
  localparam int PROD_W         = 2 * COEF_W;
  localparam int ACC_W          = PROD_W + 4;
  localparam int CFG_IDX_W      = 3;

  localparam logic [CFG_IDX_W-1:0] REG_A_GAIN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_A_FB1  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_A_FB2  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_B_GAIN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_B_FB1  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_B_FB2  = 3'd5;

  localparam logic signed [COEF_W-1:0] RST_A_GAIN = 32'sd812930000;
  localparam logic signed [COEF_W-1:0] RST_A_FB1  = 32'sd1561540000;
  localparam logic signed [COEF_W-1:0] RST_A_FB2  = 32'sd616430000;
  localparam logic signed [COEF_W-1:0] RST_B_GAIN = 32'sd740130000;
  localparam logic signed [COEF_W-1:0] RST_B_FB1  = 32'sd1374000000;
  localparam logic signed [COEF_W-1:0] RST_B_FB2  = 32'sd512820000;

  // Control for one multiply-accumulate pass.
  typedef struct packed {
    logic clr;  // clear the accumulator
    logic vld;  // a product is issued this cycle
    logic dbl;  // the product counts twice
    logic neg;  // the product is subtracted
  } mac_ctrl_t;

endpackage

[hw/rtl/stbl_hist.sv]
// History store: one synchronous memory with registered read and reset-to-zero entries.
module stbl_hist (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          we,
  input  logic [stbl_pkg::HIST_AW-1:0]  waddr,
  input  logic [stbl_pkg::HIST_W-1:0]   wdata,
  input  logic [stbl_pkg::HIST_AW-1:0]  raddr,
  output logic [stbl_pkg::HIST_W-1:0]   rdata
);
  import stbl_pkg::*;

  logic [HIST_W-1:0]     mem [HIST_DEPTH];
  logic [HIST_DEPTH-1:0] vld_r;
  logic [HIST_W-1:0]     rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // An entry never written since reset reads as zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (we) begin
      vld_r[waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= vld_r[raddr] ? mem[raddr] : '0;
  end

  assign rdata = rdata_r;

endmodule

[hw/rtl/stbl_mac.sv]
// Shared multiply-accumulate unit with half-up rounding and 32-bit saturation.
module stbl_mac (
  input  logic                        clk,
  input  logic                        rst_n,
  input  stbl_pkg::mac_ctrl_t         ctrl,
  input  logic signed [stbl_pkg::COEF_W-1:0] op_a,
  input  logic signed [stbl_pkg::HIST_W-1:0] op_b,
  output logic signed [stbl_pkg::HIST_W-1:0] y
);
  import stbl_pkg::*;

  localparam logic signed [ACC_W-1:0] YMax  = {{(ACC_W-HIST_W+1){1'b0}}, {(HIST_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] YMin  = {{(ACC_W-HIST_W+1){1'b1}}, {(HIST_W-1){1'b0}}};
  localparam logic signed [ACC_W-1:0] Half  = {{(ACC_W-1){1'b0}}, 1'b1} <<< (COEF_FRAC_BITS - 1);

  logic signed [PROD_W-1:0] prod_r;
  mac_ctrl_t                ctrl_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [ACC_W-1:0]  acc_nxt;
  logic signed [ACC_W-1:0]  term;
  logic signed [ACC_W-1:0]  rounded;
  logic signed [ACC_W-1:0]  quot;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r <= '0;
    end else begin
      ctrl_r <= ctrl;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
  end

  always_comb begin
    term = ACC_W'(prod_r);
    if (ctrl_r.dbl) begin
      term = term <<< 1;
    end
    if (ctrl_r.neg) begin
      term = -term;
    end
    acc_nxt = ctrl_r.vld ? acc_r + term : acc_r;
  end

  always_ff @(posedge clk) begin
    acc_r <= ctrl.clr ? '0 : acc_nxt;
  end

  // The exact sum is rounded half up, scaled down and clamped to the history width.
  always_comb begin
    rounded = acc_r + Half;
    quot    = rounded >>> COEF_FRAC_BITS;
    if (quot > YMax) begin
      y = YMax[HIST_W-1:0];
    end else if (quot < YMin) begin
      y = YMin[HIST_W-1:0];
    end else begin
      y = quot[HIST_W-1:0];
    end
  end

endmodule

[hw/rtl/stereo_two_stage_biquad_lowpass.sv]
// Stereo lowpass made of two cascaded direct-form-I biquad stages per channel.
//
// Each accepted item is one stereo frame; each channel runs through stage A and then
// stage B, y = g*x + 2g*x1 + g*x2 - f1*y1 - f2*y2, with Q2.30 coefficients that must
// be written through the cfg port only while the block is idle; the block itself does
// not enforce this. Stage results round half up and saturate to 32 bits; the outputs
// saturate to SAMPLE_WIDTH bits. The filter state lives in two 8-entry memories (input
// and output history) with registered reads. An accepted item runs four filter passes
// in turn on the single shared 32x32 multiplier, which forms the five products of a
// pass one per cycle; its result is then handed over to the output register and the
// block returns to idle. It accepts no new item before then, and a result still
// waiting at the output holds the block in its done state until that result is taken.
module stereo_two_stage_biquad_lowpass #(
  parameter int SAMPLE_WIDTH = 24
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      in_tvalid,
  output logic                                      in_tready,
  // sample_left, sample_right
  input  logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]       in_tdata,
  output logic                                      out_tvalid,
  input  logic                                      out_tready,
  // filtered_left, filtered_right
  output logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]       out_tdata,
  input  logic                                      cfg_we,
  input  logic [stbl_pkg::CFG_IDX_W-1:0]            cfg_index,
  input  logic [stbl_pkg::COEF_W-1:0]               cfg_wdata
);
  import stbl_pkg::*;

  localparam int TdataW = ((2*SAMPLE_WIDTH+7)/8)*8;
  localparam logic signed [HIST_W:0] OutMax =
    (({{HIST_W{1'b0}}, 1'b1}) <<< (SAMPLE_WIDTH - 1)) - {{HIST_W{1'b0}}, 1'b1};
  localparam logic signed [HIST_W:0] OutMin = -OutMax - {{HIST_W{1'b0}}, 1'b1};

  // Steps of one filter pass.
  localparam logic [3:0] STEP_RD0    = 4'd0;
  localparam logic [3:0] STEP_RD1    = 4'd1;
  localparam logic [3:0] STEP_MUL_X  = 4'd2;
  localparam logic [3:0] STEP_MUL_X1 = 4'd3;
  localparam logic [3:0] STEP_MUL_X2 = 4'd4;
  localparam logic [3:0] STEP_MUL_Y1 = 4'd5;
  localparam logic [3:0] STEP_MUL_Y2 = 4'd6;
  localparam logic [3:0] STEP_WB1    = 4'd8;
  localparam logic [3:0] STEP_WB0    = 4'd9;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t st_r, st_nxt;
  logic [3:0] step_r, step_nxt;
  logic [1:0] job_r, job_nxt;

  logic signed [COEF_W-1:0] a_g_r, a_f1_r, a_f2_r, b_g_r, b_f1_r, b_f2_r;
  logic signed [HIST_W-1:0] in_l_r, in_r_r;
  logic signed [HIST_W-1:0] x_r, x1_r, x2_r, y1_r, y2_r, y_r;
  logic [SAMPLE_WIDTH-1:0]  res_l_r, res_r_r;
  logic                     out_tvalid_r;
  logic [TdataW-1:0]        out_tdata_r;

  logic                     stage, chan, in_acc, run;
  logic [HIST_AW-1:0]       addr0, addr1, raddr, waddr;
  logic                     hist_we;
  logic [HIST_W-1:0]        xh_wdata, yh_wdata, xh_rdata, yh_rdata;
  logic signed [COEF_W-1:0] coef_g, coef_f1, coef_f2, op_a;
  logic signed [HIST_W-1:0] op_b, mac_y;
  mac_ctrl_t                mac_ctrl;
  logic signed [HIST_W:0]   y_ext;
  logic [SAMPLE_WIDTH-1:0]  y_sat;

  // Job order: stage A left, stage B left, stage A right, stage B right.
  assign stage  = job_r[0];
  assign chan   = job_r[1];
  assign run    = (st_r == ST_RUN);
  assign in_acc = in_tvalid && in_tready;
  assign addr0  = {stage, chan, 1'b0};
  assign addr1  = {stage, chan, 1'b1};
  assign raddr  = (step_r == STEP_RD1) ? addr1 : addr0;
  assign hist_we  = run && ((step_r == STEP_WB1) || (step_r == STEP_WB0));
  assign waddr    = (step_r == STEP_WB1) ? addr1 : addr0;
  assign xh_wdata = (step_r == STEP_WB1) ? x1_r : x_r;
  assign yh_wdata = (step_r == STEP_WB1) ? y1_r : y_r;

  assign in_tready  = (st_r == ST_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  stbl_hist u_xhist (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (hist_we),
    .waddr (waddr),
    .wdata (xh_wdata),
    .raddr (raddr),
    .rdata (xh_rdata)
  );

  stbl_hist u_yhist (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (hist_we),
    .waddr (waddr),
    .wdata (yh_wdata),
    .raddr (raddr),
    .rdata (yh_rdata)
  );

  always_comb begin
    coef_g  = stage ? b_g_r  : a_g_r;
    coef_f1 = stage ? b_f1_r : a_f1_r;
    coef_f2 = stage ? b_f2_r : a_f2_r;
    case (step_r)
      STEP_MUL_X: begin
        op_a = coef_g;
        op_b = x_r;
      end
      STEP_MUL_X1: begin
        op_a = coef_g;
        op_b = x1_r;
      end
      STEP_MUL_X2: begin
        op_a = coef_g;
        op_b = x2_r;
      end
      STEP_MUL_Y1: begin
        op_a = coef_f1;
        op_b = y1_r;
      end
      STEP_MUL_Y2: begin
        op_a = coef_f2;
        op_b = y2_r;
      end
      default: begin
        op_a = coef_g;
        op_b = x_r;
      end
    endcase
    mac_ctrl.clr = run && (step_r == STEP_RD1);
    mac_ctrl.vld = run && (step_r inside {[STEP_MUL_X:STEP_MUL_Y2]});
    mac_ctrl.dbl = (step_r == STEP_MUL_X1);
    mac_ctrl.neg = (step_r == STEP_MUL_Y1) || (step_r == STEP_MUL_Y2);
  end

  stbl_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (mac_ctrl),
    .op_a  (op_a),
    .op_b  (op_b),
    .y     (mac_y)
  );

  always_comb begin
    y_ext = {y_r[HIST_W-1], y_r};
    if (y_ext > OutMax) begin
      y_sat = OutMax[SAMPLE_WIDTH-1:0];
    end else if (y_ext < OutMin) begin
      y_sat = OutMin[SAMPLE_WIDTH-1:0];
    end else begin
      y_sat = y_r[SAMPLE_WIDTH-1:0];
    end
  end

  always_comb begin
    st_nxt   = st_r;
    step_nxt = step_r;
    job_nxt  = job_r;
    case (st_r)
      ST_IDLE: begin
        if (in_acc) begin
          st_nxt   = ST_RUN;
          step_nxt = STEP_RD0;
          job_nxt  = '0;
        end
      end
      ST_RUN: begin
        if (step_r == STEP_WB0) begin
          step_nxt = STEP_RD0;
          job_nxt  = job_r + 2'd1;
          if (job_r == 2'd3) begin
            st_nxt = ST_DONE;
          end
        end else begin
          step_nxt = step_r + 4'd1;
        end
      end
      ST_DONE: begin
        if (!out_tvalid_r || out_tready) begin
          st_nxt = ST_IDLE;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= ST_IDLE;
      step_r       <= STEP_RD0;
      job_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      step_r <= step_nxt;
      job_r  <= job_nxt;
      if ((st_r == ST_DONE) && (!out_tvalid_r || out_tready)) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_g_r  <= RST_A_GAIN;
      a_f1_r <= RST_A_FB1;
      a_f2_r <= RST_A_FB2;
      b_g_r  <= RST_B_GAIN;
      b_f1_r <= RST_B_FB1;
      b_f2_r <= RST_B_FB2;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_A_GAIN: a_g_r  <= cfg_wdata;
        REG_A_FB1:  a_f1_r <= cfg_wdata;
        REG_A_FB2:  a_f2_r <= cfg_wdata;
        REG_B_GAIN: b_g_r  <= cfg_wdata;
        REG_B_FB1:  b_f1_r <= cfg_wdata;
        REG_B_FB2:  b_f2_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // Datapath registers of the pass.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_l_r <= HIST_W'($signed(in_tdata[SAMPLE_WIDTH-1:0]));
      in_r_r <= HIST_W'($signed(in_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH]));
    end
    if (run) begin
      case (step_r)
        STEP_RD0: begin
          // Stage B filters the previous pass's result of the same channel.
          x_r <= stage ? y_r : (chan ? in_r_r : in_l_r);
        end
        STEP_RD1: begin
          x1_r <= xh_rdata;
          y1_r <= yh_rdata;
        end
        STEP_MUL_X: begin
          x2_r <= xh_rdata;
          y2_r <= yh_rdata;
        end
        STEP_WB1: begin
          y_r <= mac_y;
        end
        STEP_WB0: begin
          if (stage) begin
            if (chan) begin
              res_r_r <= y_sat;
            end else begin
              res_l_r <= y_sat;
            end
          end
        end
        default: begin
        end
      endcase
    end
    if ((st_r == ST_DONE) && (!out_tvalid_r || out_tready)) begin
      out_tdata_r <= TdataW'({res_r_r, res_l_r});
    end
  end

  a_accept_starts_pass: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (st_r == ST_RUN) && (step_r == STEP_RD0) && (job_r == 2'd0))
    else $error("accepted item did not start the first filter pass");

  a_wb_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    hist_we |-> run && ((step_r == STEP_WB1) || (step_r == STEP_WB0)))
    else $error("history written outside the write-back steps");

  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    run |-> (step_r <= STEP_WB0))
    else $error("pass step counter out of range");

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid_r) |-> $past(st_r == ST_DONE))
    else $error("result presented without a finished item");

endmodule
